>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/uhb_pkg.sv
// shared types, byte codes and result helpers of the frame parser
// no dependencies
package uhb_pkg;

	localparam int MAX_RESULTS    = 5;
	localparam int RES_CNT_W      = 3;
	localparam int KB_FRAME_BYTES = 80;
	localparam int VIDPID_PORTS   = 2;

	localparam logic [7:0] HDR_0 = 8'h57;
	localparam logic [7:0] HDR_1 = 8'hAB;

	localparam logic [7:0] CMD_TIMEOUT    = 8'h89;
	localparam logic [7:0] CMD_DISCONNECT = 8'h86;
	localparam logic [7:0] CMD_VERSION    = 8'h87;
	localparam logic [7:0] CMD_NOP        = 8'h84;
	localparam logic [7:0] CMD_STATE_REQ  = 8'h82;
	localparam logic [7:0] CMD_STATUS     = 8'h80;
	localparam logic [7:0] CMD_SKIP_ONE   = 8'h85;
	localparam logic [7:0] CMD_KEYBOARD   = 8'h83;
	localparam logic [7:0] CMD_MOUSE      = 8'h88;
	localparam logic [7:0] CMD_VIDPID     = 8'h81;

	localparam logic [7:0] KB_LEN_LIMIT = 8'd76;

	localparam logic [3:0] EV_NONE         = 4'd0;
	localparam logic [3:0] EV_TIMEOUT      = 4'd1;
	localparam logic [3:0] EV_DISCONNECT   = 4'd2;
	localparam logic [3:0] EV_VERSION      = 4'd3;
	localparam logic [3:0] EV_STATE_REQ    = 4'd4;
	localparam logic [3:0] EV_STATUS       = 4'd5;
	localparam logic [3:0] EV_VIDPID_START = 4'd6;
	localparam logic [3:0] EV_VIDPID_DONE  = 4'd7;
	localparam logic [3:0] EV_KB_DONE      = 4'd8;
	localparam logic [3:0] EV_UNKNOWN_CMD  = 4'd9;
	localparam logic [3:0] EV_KB_LEN_ERR   = 4'd10;
	localparam logic [3:0] EV_VP_LEN_ERR   = 4'd11;

	localparam logic TGT_KB     = 1'b0;
	localparam logic TGT_VIDPID = 1'b1;

	typedef struct packed {
		logic [3:0] event_res;
		logic [7:0] event_value;
		logic       store_valid;
		logic       store_target;
		logic       store_port;
		logic [9:0] store_index;
		logic [7:0] store_data;
		logic       last;
	} result_t;

	// all results caused by one byte
	typedef struct packed {
		result_t [MAX_RESULTS-1:0] rec;
		logic [RES_CNT_W-1:0]      cnt;
	} batch_t;

	function automatic result_t make_event(input logic [3:0] ev, input logic [7:0] val);
		result_t r;
		r             = '0;
		r.event_res   = ev;
		r.event_value = val;
		return r;
	endfunction

	function automatic result_t make_store(input logic tgt, input logic port,
		input logic [9:0] idx, input logic [7:0] data);
		result_t r;
		r              = '0;
		r.store_valid  = 1'b1;
		r.store_target = tgt;
		r.store_port   = port;
		r.store_index  = idx;
		r.store_data   = data;
		return r;
	endfunction

endpackage

>>> rtl/core/uhb_parse.sv
// frame state machine: parser state and the results of one byte
// depends on uhb_pkg
module uhb_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      byte_s1,
	output uhb_pkg::batch_t batch
);

	typedef enum logic [2:0] {
		P_HDR0  = 3'd0,
		P_HDR1  = 3'd1,
		P_CMD   = 3'd2,
		P_BYTE3 = 3'd3,
		P_BYTE4 = 3'd4,
		P_BYTE5 = 3'd5,
		P_BODY  = 3'd6,
		P_BAD   = 3'd7
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] cmd_q, cmd_n;
	logic       port_q, port_n;
	logic [6:0] kb_pos_q, kb_pos_n;
	logic [6:0] kb_len_q, kb_len_n;
	logic [9:0] vp_pos_q, vp_pos_n;
	logic [9:0] vp_size_q, vp_size_n;

	logic       vp;
	logic [6:0] kb_pos_inc;
	logic [9:0] vp_pos_inc;
	logic [8:0] kb_len_sum;

	assign vp         = (cmd_q == uhb_pkg::CMD_VIDPID);
	assign kb_pos_inc = kb_pos_q + 7'd1;
	assign vp_pos_inc = vp_pos_q + 10'd1;
	assign kb_len_sum = {1'b0, byte_s1} + 9'd4;

	always_comb begin
		phase_n   = phase_q;
		cmd_n     = cmd_q;
		port_n    = port_q;
		kb_pos_n  = kb_pos_q;
		kb_len_n  = kb_len_q;
		vp_pos_n  = vp_pos_q;
		vp_size_n = vp_size_q;
		batch     = '0;

		case (phase_q)
			P_HDR0: begin
				phase_n = (byte_s1 == uhb_pkg::HDR_0) ? P_HDR1 : P_HDR0;
			end
			P_HDR1: begin
				phase_n = (byte_s1 == uhb_pkg::HDR_1) ? P_CMD : P_HDR0;
			end
			P_CMD: begin
				cmd_n   = byte_s1;
				phase_n = P_HDR0;
				case (byte_s1)
					uhb_pkg::CMD_TIMEOUT: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_TIMEOUT, 8'd0);
						batch.cnt    = 3'd1;
					end
					uhb_pkg::CMD_DISCONNECT: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_DISCONNECT, 8'd0);
						batch.cnt    = 3'd1;
					end
					uhb_pkg::CMD_VERSION: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_VERSION, 8'd0);
						batch.cnt    = 3'd1;
					end
					uhb_pkg::CMD_NOP: begin
						phase_n = P_HDR0;
					end
					uhb_pkg::CMD_STATE_REQ, uhb_pkg::CMD_STATUS, uhb_pkg::CMD_SKIP_ONE: begin
						phase_n = P_BYTE3;
					end
					uhb_pkg::CMD_KEYBOARD, uhb_pkg::CMD_MOUSE: begin
						batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_KB, 1'b0, 10'd2, byte_s1);
						batch.cnt    = 3'd1;
						phase_n      = P_BYTE3;
					end
					uhb_pkg::CMD_VIDPID: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_VIDPID_START, 8'd0);
						batch.cnt    = 3'd1;
						phase_n      = P_BYTE3;
					end
					default: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_UNKNOWN_CMD, 8'd0);
						batch.cnt    = 3'd1;
					end
				endcase
			end
			P_BYTE3: begin
				phase_n = P_HDR0;
				case (cmd_q)
					uhb_pkg::CMD_STATE_REQ: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_STATE_REQ, byte_s1);
						batch.cnt    = 3'd1;
					end
					uhb_pkg::CMD_STATUS: begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_STATUS, 8'd0);
						batch.cnt    = 3'd1;
					end
					uhb_pkg::CMD_VIDPID: begin
						port_n  = byte_s1[0] && (uhb_pkg::VIDPID_PORTS > 1);
						phase_n = P_BYTE4;
					end
					uhb_pkg::CMD_KEYBOARD, uhb_pkg::CMD_MOUSE: begin
						batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_KB, 1'b0, 10'd3, byte_s1);
						if (byte_s1 > uhb_pkg::KB_LEN_LIMIT ||
							kb_len_sum > 9'(uhb_pkg::KB_FRAME_BYTES)) begin
							batch.rec[1] = uhb_pkg::make_event(uhb_pkg::EV_KB_LEN_ERR, 8'd0);
							batch.cnt    = 3'd2;
						end else begin
							batch.cnt = 3'd1;
							kb_len_n  = byte_s1[6:0];
							phase_n   = P_BYTE4;
						end
					end
					default: begin
						phase_n = P_HDR0;
					end
				endcase
			end
			P_BYTE4: begin
				phase_n = P_BYTE5;
				if (vp) begin
					// replay the frame header into the port buffer
					batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, 10'd0,
						uhb_pkg::HDR_0);
					batch.rec[1] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, 10'd1,
						uhb_pkg::HDR_1);
					batch.rec[2] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, 10'd2,
						uhb_pkg::CMD_VIDPID);
					batch.rec[3] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, 10'd3,
						{7'd0, port_q});
					batch.rec[4] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, 10'd4,
						byte_s1);
					batch.cnt    = 3'd5;
					vp_size_n    = {2'b00, byte_s1} + 10'd9;
				end else begin
					batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_KB, 1'b0, 10'd4, byte_s1);
					batch.cnt    = 3'd1;
				end
			end
			P_BYTE5: begin
				if (vp) begin
					if (byte_s1 < 8'd2) begin
						batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, 10'd5,
							byte_s1);
						batch.cnt    = 3'd1;
						vp_size_n    = vp_size_q + {1'b0, byte_s1[0], 8'd0};
						vp_pos_n     = 10'd6;
						phase_n      = P_BODY;
					end else begin
						batch.rec[0] = uhb_pkg::make_event(uhb_pkg::EV_VP_LEN_ERR, 8'd0);
						batch.cnt    = 3'd1;
						phase_n      = P_HDR0;
					end
				end else begin
					batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_KB, 1'b0, 10'd5, byte_s1);
					batch.cnt    = 3'd1;
					kb_pos_n     = 7'd6;
					phase_n      = P_BODY;
				end
			end
			P_BODY: begin
				if (vp) begin
					batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_VIDPID, port_q, vp_pos_q,
						byte_s1);
					if (vp_pos_inc == vp_size_q) begin
						batch.rec[1] = uhb_pkg::make_event(uhb_pkg::EV_VIDPID_DONE,
							{7'd0, port_q});
						batch.cnt    = 3'd2;
						vp_pos_n     = 10'd0;
						phase_n      = P_HDR0;
					end else begin
						batch.cnt = 3'd1;
						vp_pos_n  = vp_pos_inc;
					end
				end else begin
					batch.rec[0] = uhb_pkg::make_store(uhb_pkg::TGT_KB, 1'b0,
						{3'd0, kb_pos_q}, byte_s1);
					kb_pos_n     = kb_pos_inc;
					if ({1'b0, kb_pos_inc} > {1'b0, kb_len_q} + 8'd3) begin
						batch.rec[1] = uhb_pkg::make_event(uhb_pkg::EV_KB_DONE, 8'd0);
						batch.cnt    = 3'd2;
						phase_n      = P_HDR0;
					end else begin
						batch.cnt = 3'd1;
					end
				end
			end
			default: begin
				phase_n = P_HDR0;
			end
		endcase

		// flag the final result of the byte
		for (int k = 0; k < uhb_pkg::MAX_RESULTS; k++) begin
			batch.rec[k].last = (batch.cnt == uhb_pkg::RES_CNT_W'(k + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_HDR0;
			cmd_q     <= '0;
			port_q    <= 1'b0;
			kb_pos_q  <= '0;
			kb_len_q  <= '0;
			vp_pos_q  <= '0;
			vp_size_q <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			cmd_q     <= cmd_n;
			port_q    <= port_n;
			kb_pos_q  <= kb_pos_n;
			kb_len_q  <= kb_len_n;
			vp_pos_q  <= vp_pos_n;
			vp_size_q <= vp_size_n;
		end
	end

endmodule

>>> rtl/core/uhb_result_buf.sv
// result register: holds one byte's results and hands them out one beat a cycle while out_stall is low
// depends on uhb_pkg
module uhb_result_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  uhb_pkg::batch_t  batch,
	input  logic             out_stall,
	output logic             out_valid,
	output uhb_pkg::result_t head,
	output logic             free
);

	uhb_pkg::result_t [uhb_pkg::MAX_RESULTS-1:0] rec_q;
	logic                                       busy_q;
	logic [uhb_pkg::RES_CNT_W-1:0]              rd_q;
	logic                                       take;

	assign head      = rec_q[rd_q];
	assign out_valid = busy_q;
	assign take      = busy_q && !out_stall;
	assign free      = !busy_q || (take && head.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q   <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			rd_q   <= '0;
		end else if (take) begin
			if (head.last) begin
				busy_q <= 1'b0;
			end else begin
				rd_q <= rd_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= batch.rec;
		end
	end

endmodule

>>> rtl/core/usb_hid_bridge_frame_parser.sv
// a taken byte passes through the input register and then the result register
// throughput: one byte per cycle while out_stall is low and each byte gives at most
// one result; n results of a byte (five at vid/pid header) hold the result register
// reset: arst_n clears the parser to wait for the first header byte and empties
// both the input register and the result register
`include "assert_macros.svh"

module usb_hid_bridge_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] event_res,
	output logic [7:0] event_value,
	output logic       store_valid,
	output logic       store_target,
	output logic       store_port,
	output logic [9:0] store_index,
	output logic [7:0] store_data,
	output logic       last
);

	// input register: one received byte waiting for the parser
	logic       valid_s1;
	logic [7:0] byte_s1;

	logic             buf_free;
	logic             advance;
	logic             accept;
	logic             load;
	uhb_pkg::batch_t  batch;
	uhb_pkg::result_t head;

	// the byte moves on when the result register is empty or hands out its
	// final beat in this cycle
	assign advance  = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;
	assign accept   = in_valid && !in_stall;
	// bytes without results only advance the parser state
	assign load     = advance && (batch.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame state and result generation, state steps once per byte
	uhb_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.batch   (batch)
	);

	// result register, one beat per cycle while out_stall is low
	uhb_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.batch     (batch),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.free      (buf_free)
	);

	assign event_res    = head.event_res;
	assign event_value  = head.event_value;
	assign store_valid  = head.store_valid;
	assign store_target = head.store_target;
	assign store_port   = head.store_port;
	assign store_index  = head.store_index;
	assign store_data   = head.store_data;
	assign last         = head.last;

	// input only backs up behind pending results
	`ASSERT_IMPL(a_stall_needs_results, clk, arst_n, in_stall, out_valid)
	// a store beat carries no event
	`ASSERT_IMPL(a_store_no_event, clk, arst_n, out_valid && store_valid, event_res == uhb_pkg::EV_NONE && event_value == 8'd0)
	// a taken beat that is not the last is followed by another beat
	`ASSERT_NEXT(a_burst_continues, clk, arst_n, out_valid && !out_stall && !last, out_valid)
	// a port number only appears on vid/pid stores
	`ASSERT_IMPL(a_port_only_vidpid, clk, arst_n, out_valid && store_port, store_valid && store_target)

endmodule
